@@ hdl/rthsl_pkg.sv @@
// Shared widths, lane codes and constants for the RGB to HSL pixel converter.
`default_nettype none
package rthsl_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned DEN_W = 12;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned LANES = 4;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned LANE_HUE = 0;
  localparam int unsigned LANE_SAT = 1;
  localparam int unsigned LANE_LIGHT = 2;
  localparam int unsigned LANE_ALPHA = 3;

  localparam logic [DEN_W-1:0] CH_MAX = DEN_W'(255);
  localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(510);

endpackage
`default_nettype wire

@@ hdl/rthsl_prep.sv @@
// Input stage: channel extremes and the dividend and divisor of every quotient lane.
`default_nettype none
module rthsl_prep #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             s_valid,
  output logic                                                  s_ready,
  input  wire logic [rthsl_pkg::CH_W-1:0]                       red,
  input  wire logic [rthsl_pkg::CH_W-1:0]                       green,
  input  wire logic [rthsl_pkg::CH_W-1:0]                       blue,
  input  wire logic [rthsl_pkg::CH_W-1:0]                       alpha,
  output logic                                                  m_valid,
  input  wire logic                                             m_ready,
  output logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0]     m_rem,
  output logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0]        m_wq,
  output logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0]     m_div
);

  localparam int unsigned DW = rthsl_pkg::DEN_W;
  localparam int unsigned NW = FRACTION_BITS + DW;

  logic                          valid_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            rem_r;
  logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0] wq_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            div_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            rem_nxt;
  logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0] wq_nxt;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            div_nxt;

  logic [rthsl_pkg::CH_W-1:0] hi;
  logic [rthsl_pkg::CH_W-1:0] lo;
  logic [DW-1:0]              r_x;
  logic [DW-1:0]              g_x;
  logic [DW-1:0]              b_x;
  logic [DW-1:0]              sum;
  logic [DW-1:0]              spread;
  logic [DW-1:0]              six_spread;
  logic [DW-1:0]              hue_num;
  logic [rthsl_pkg::LANES-1:0][DW-1:0] num;
  logic [rthsl_pkg::LANES-1:0][DW-1:0] den;
  logic [rthsl_pkg::LANES-1:0][NW-1:0] dividend;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_rem   = rem_r;
  assign m_wq    = wq_r;
  assign m_div   = div_r;

  always_comb begin
    hi = red;
    if (green > hi) begin
      hi = green;
    end
    if (blue > hi) begin
      hi = blue;
    end
    lo = red;
    if (green < lo) begin
      lo = green;
    end
    if (blue < lo) begin
      lo = blue;
    end

    r_x        = DW'(red);
    g_x        = DW'(green);
    b_x        = DW'(blue);
    sum        = DW'(hi) + DW'(lo);
    spread     = DW'(hi) - DW'(lo);
    six_spread = (spread << 2) + (spread << 1);

    // Hue numerator in sixths of a turn; the sums never leave the 12-bit range.
    if (r_x > g_x && r_x > b_x) begin
      if (g_x < b_x) begin
        hue_num = six_spread - (b_x - g_x);
      end else begin
        hue_num = g_x - b_x;
      end
    end else if (g_x > b_x) begin
      hue_num = (spread << 1) + b_x - r_x;
    end else begin
      hue_num = (spread << 2) + r_x - g_x;
    end

    // A grey pixel divides zero by one, which gives zero hue and saturation.
    if (spread == '0) begin
      num[rthsl_pkg::LANE_HUE] = '0;
      den[rthsl_pkg::LANE_HUE] = DW'(1);
      num[rthsl_pkg::LANE_SAT] = '0;
      den[rthsl_pkg::LANE_SAT] = DW'(1);
    end else begin
      num[rthsl_pkg::LANE_HUE] = hue_num;
      den[rthsl_pkg::LANE_HUE] = six_spread;
      num[rthsl_pkg::LANE_SAT] = spread;
      if (sum > rthsl_pkg::CH_MAX) begin
        den[rthsl_pkg::LANE_SAT] = rthsl_pkg::LIGHT_DEN - sum;
      end else begin
        den[rthsl_pkg::LANE_SAT] = sum;
      end
    end
    num[rthsl_pkg::LANE_LIGHT] = sum;
    den[rthsl_pkg::LANE_LIGHT] = rthsl_pkg::LIGHT_DEN;
    num[rthsl_pkg::LANE_ALPHA] = DW'(alpha);
    den[rthsl_pkg::LANE_ALPHA] = rthsl_pkg::CH_MAX;

    // Rounded quotient: floor((2*num*scale + den) / (2*den)), scale = 2^F - 1.
    for (int unsigned i = 0; i < rthsl_pkg::LANES; i++) begin
      dividend[i] = (NW'(num[i]) << (FRACTION_BITS + 1)) - (NW'(num[i]) << 1)
                    + NW'(den[i]);
      rem_nxt[i]  = dividend[i][NW-1:FRACTION_BITS];
      wq_nxt[i]   = dividend[i][FRACTION_BITS-1:0];
      div_nxt[i]  = den[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      rem_r <= rem_nxt;
      wq_r  <= wq_nxt;
      div_r <= div_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rthsl_cell.sv @@
// Divider cell: resolves one quotient bit in each lane and hands the beat on.
`default_nettype none
module rthsl_cell #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             s_valid,
  output logic                                                  s_ready,
  input  wire logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0] s_rem,
  input  wire logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0]    s_wq,
  input  wire logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0] s_div,
  output logic                                                  m_valid,
  input  wire logic                                             m_ready,
  output logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0]     m_rem,
  output logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0]        m_wq,
  output logic [rthsl_pkg::LANES-1:0][rthsl_pkg::DEN_W-1:0]     m_div
);

  localparam int unsigned DW = rthsl_pkg::DEN_W;

  logic                                           valid_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            rem_r;
  logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0] wq_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            div_r;
  logic [rthsl_pkg::LANES-1:0][DW-1:0]            rem_nxt;
  logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0] wq_nxt;
  logic [rthsl_pkg::LANES-1:0][DW:0]              trial;
  logic [rthsl_pkg::LANES-1:0]                    fits;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_rem   = rem_r;
  assign m_wq    = wq_r;
  assign m_div   = div_r;

  // Restoring step: the next dividend bit leaves the top of wq, the quotient
  // bit enters at its bottom.
  always_comb begin
    for (int unsigned i = 0; i < rthsl_pkg::LANES; i++) begin
      trial[i]   = {s_rem[i], s_wq[i][FRACTION_BITS-1]};
      fits[i]    = trial[i] >= {1'b0, s_div[i]};
      rem_nxt[i] = fits[i] ? DW'(trial[i] - {1'b0, s_div[i]}) : DW'(trial[i]);
      wq_nxt[i]  = {s_wq[i][FRACTION_BITS-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      rem_r <= rem_nxt;
      wq_r  <= wq_nxt;
      div_r <= s_div;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rgb_to_hsl_pixel.sv @@
// Top level of the RGBA to HSL pixel converter.
//
// Converts one RGBA pixel per clock, unless the output stalls, into hue,
// saturation, lightness and alpha as rounded unsigned fractions of
// 2^FRACTION_BITS - 1 (hue wraps a full turn to zero, outputs keep their low
// 16 bits). Every pixel passes one input stage that finds the channel extremes
// and forms the four dividends, then a row of FRACTION_BITS divider cells, each
// settling one quotient bit of all four lanes. A new beat is taken every cycle
// unless the output stalls; each stage holds its beat while the next one cannot
// take it, so idle stages fill up under output stalls and the last cell serves
// as the output register.
`default_nettype none
module rgb_to_hsl_pixel #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0 up: red, green, blue, alpha.
  input  wire logic [rthsl_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // Fields from bit 0 up: hue, saturation, lightness, alpha_fraction.
  output logic [rthsl_pkg::OUT_DATA_W-1:0]         out_tdata
);

  localparam int unsigned DW = rthsl_pkg::DEN_W;
  localparam int unsigned CW = rthsl_pkg::CH_W;
  localparam int unsigned OW = rthsl_pkg::OUT_W;

  logic [FRACTION_BITS:0]                                            valid_c;
  logic [FRACTION_BITS:0]                                            ready_c;
  logic [FRACTION_BITS:0][rthsl_pkg::LANES-1:0][DW-1:0]              rem_c;
  logic [FRACTION_BITS:0][rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0]   wq_c;
  logic [FRACTION_BITS:0][rthsl_pkg::LANES-1:0][DW-1:0]              div_c;
  logic [rthsl_pkg::LANES-1:0][FRACTION_BITS-1:0]                    quot;
  logic [rthsl_pkg::LANES-1:0][OW-1:0]                               field;

  rthsl_prep #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .red     (in_tdata[CW-1:0]),
    .green   (in_tdata[2*CW-1:CW]),
    .blue    (in_tdata[3*CW-1:2*CW]),
    .alpha   (in_tdata[4*CW-1:3*CW]),
    .m_valid (valid_c[0]),
    .m_ready (ready_c[0]),
    .m_rem   (rem_c[0]),
    .m_wq    (wq_c[0]),
    .m_div   (div_c[0])
  );

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    rthsl_cell #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (valid_c[k]),
      .s_ready (ready_c[k]),
      .s_rem   (rem_c[k]),
      .s_wq    (wq_c[k]),
      .s_div   (div_c[k]),
      .m_valid (valid_c[k+1]),
      .m_ready (ready_c[k+1]),
      .m_rem   (rem_c[k+1]),
      .m_wq    (wq_c[k+1]),
      .m_div   (div_c[k+1])
    );
  end

  assign ready_c[FRACTION_BITS] = out_tready;
  assign out_tvalid = valid_c[FRACTION_BITS];

  // A hue of exactly one full turn wraps to zero.
  always_comb begin
    quot = wq_c[FRACTION_BITS];
    if (quot[rthsl_pkg::LANE_HUE] == {FRACTION_BITS{1'b1}}) begin
      quot[rthsl_pkg::LANE_HUE] = '0;
    end
  end

  for (genvar i = 0; i < rthsl_pkg::LANES; i++) begin : g_field
    if (FRACTION_BITS >= OW) begin : g_cut
      assign field[i] = quot[i][OW-1:0];
    end else begin : g_ext
      assign field[i] = {{(OW-FRACTION_BITS){1'b0}}, quot[i]};
    end
  end

  assign out_tdata = {field[rthsl_pkg::LANE_ALPHA], field[rthsl_pkg::LANE_LIGHT],
                      field[rthsl_pkg::LANE_SAT], field[rthsl_pkg::LANE_HUE]};

endmodule
`default_nettype wire

@@ test/rgb_to_hsl_pixel_tb.sv @@
// Testbench for the RGBA to HSL pixel converter: directed and random pixels.
module rgb_to_hsl_pixel_tb;

  localparam int unsigned CH_W = rthsl_pkg::CH_W;
  localparam int unsigned OUT_W = rthsl_pkg::OUT_W;
  localparam int unsigned IN_DATA_W = rthsl_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = rthsl_pkg::OUT_DATA_W;
  localparam int unsigned FRACTION_BITS = 16;
  localparam longint unsigned FRAC_SCALE = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam int RANDOM_PIXELS = 1600;
  localparam int CALM_PIXELS = 150;
  localparam int DIRECTED_ROWS = 20;
  localparam int DRAIN_CYCLES = 2 * FRACTION_BITS + 16;

  typedef struct packed {
    logic [OUT_W-1:0] alpha_frac;
    logic [OUT_W-1:0] lightness;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] hue;
  } hsl_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    bit typed;
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] lightness;
    logic [OUT_W-1:0] alpha_frac;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  hsl_t hsl_expected_q [$];
  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     16'd0,     16'd0,     16'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 16'd0,     16'd0,     16'd65535, 16'd65535},
    '{8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 16'd0,     16'd0,     16'd32896, 16'd32896},
    '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 16'd0,     16'd65535, 16'd32768, 16'd65535},
    '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 16'd21845, 16'd65535, 16'd32768, 16'd0},
    '{8'd0,   8'd0,   8'd255, 8'd1,   1'b1, 16'd43690, 16'd65535, 16'd32768, 16'd257},
    '{8'd255, 8'd0,   8'd1,   8'd85,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd1,   8'd0,   8'd170, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd200, 8'd200, 8'd0,   8'd2,   1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd200, 8'd0,   8'd200, 8'd4,   1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd200, 8'd200, 8'd8,   1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd255, 8'd0,   8'd16,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd1,   8'd1,   8'd32,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd128, 8'd127, 8'd127, 8'd64,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd128, 8'd128, 8'd127, 8'd127, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd1,   8'd0,   8'd0,   8'd254, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd1,   8'd0,   8'd253, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd254, 8'd255, 8'd251, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd10,  8'd20,  8'd30,  8'd247, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{8'd85,  8'd170, 8'd240, 8'd239, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  rgb_to_hsl_pixel #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned round_fraction(longint unsigned num,
                                                     longint unsigned den);
    if (den == 0) begin
      return 0;
    end
    return (2 * num * FRAC_SCALE + den) / (2 * den);
  endfunction

  function automatic hsl_t convert_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    longint unsigned rv, gv, bv, hi, lo, sum, spread, num, hue_full;
    hsl_t res;
    rv = r;
    gv = g;
    bv = b;
    hi = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    lo = rv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    sum = hi + lo;
    spread = hi - lo;
    res = '0;
    res.lightness = OUT_W'(round_fraction(sum, 510));
    res.alpha_frac = OUT_W'(round_fraction(a, 255));
    if (spread != 0) begin
      if (sum > 255) begin
        res.saturation = OUT_W'(round_fraction(spread, 510 - sum));
      end else begin
        res.saturation = OUT_W'(round_fraction(spread, sum));
      end
      // The hue numerator counts sixths of a turn in units of 1/spread.
      if (rv > gv && rv > bv) begin
        num = (gv < bv) ? 6 * spread - (bv - gv) : gv - bv;
      end else if (gv > bv) begin
        num = 2 * spread + bv - rv;
      end else begin
        num = 4 * spread + rv - gv;
      end
      hue_full = round_fraction(num, 6 * spread);
      if (hue_full >= FRAC_SCALE) hue_full = 0;
      res.hue = OUT_W'(hue_full);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b, logic [CH_W-1:0] a, hsl_t want);
    int n;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      n = $urandom_range(13, 1);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {a, b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hsl_expected_q.push_back(want);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(12, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hsl_t got;
    hsl_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (hsl_expected_q.size() == 0) begin
        report_mismatch("beat with nothing pending, data", 0, out_tdata);
      end else begin
        want = hsl_expected_q.pop_front();
        if (got.hue !== want.hue) report_mismatch("hue", want.hue, got.hue);
        if (got.saturation !== want.saturation) begin
          report_mismatch("saturation", want.saturation, got.saturation);
        end
        if (got.lightness !== want.lightness) begin
          report_mismatch("lightness", want.lightness, got.lightness);
        end
        if (got.alpha_frac !== want.alpha_frac) begin
          report_mismatch("alpha_fraction", want.alpha_frac, got.alpha_frac);
        end
      end
    end
  end

  initial begin
    hsl_t want;
    pixel_row_t row;
    logic [CH_W-1:0] r, g, b, a;
    logic [CH_W-1:0] corner [6];
    int pick;
    corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 20;
    stall_pct = 20;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.typed) begin
        want.hue = row.hue;
        want.saturation = row.saturation;
        want.lightness = row.lightness;
        want.alpha_frac = row.alpha_frac;
      end else begin
        want = convert_pixel(row.red, row.green, row.blue, row.alpha);
      end
      send_pixel(row.red, row.green, row.blue, row.alpha, want);
    end

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i >= RANDOM_PIXELS - CALM_PIXELS) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (i % 200 == 0) begin
        pick = $urandom_range(3);
        gap_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : (pick == 2) ? 25 : 50;
        pick = $urandom_range(3);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : (pick == 2) ? 25 : 50;
      end
      r = CH_W'($urandom_range(255));
      g = CH_W'($urandom_range(255));
      b = CH_W'($urandom_range(255));
      a = CH_W'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick == 0) begin
        g = r;
        b = r;
      end else if (pick == 1) begin
        // Two channels share the largest value.
        case ($urandom_range(2))
          0: begin g = r; b = CH_W'($urandom_range(r)); end
          1: begin b = r; g = CH_W'($urandom_range(r)); end
          default: begin b = g; r = CH_W'($urandom_range(g)); end
        endcase
      end else if (pick == 2) begin
        r = corner[$urandom_range(5)];
        g = corner[$urandom_range(5)];
        b = corner[$urandom_range(5)];
        a = corner[$urandom_range(5)];
      end
      send_pixel(r, g, b, a, convert_pixel(r, g, b, a));
    end
    in_tvalid <= 1'b0;

    while (hsl_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ rgb_to_hsl_pixel.f @@
hdl/rthsl_pkg.sv
hdl/rthsl_prep.sv
hdl/rthsl_cell.sv
hdl/rgb_to_hsl_pixel.sv
test/rgb_to_hsl_pixel_tb.sv
